// ----- design/assert_macros.svh -----
// Assertion helpers used by the palette indexer unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CPDI_ASSERT_AT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define CPDI_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cpdi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cpdi_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int COLOR_W           = 32;
    localparam int INDEX_OUT_W       = 8;

    typedef logic [COLOR_W-1:0] cpdi_color_t;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_CLEAR = 1'b1
    } cpdi_op_e;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } cpdi_state_e;

    // Control flags that ride along with a search token.
    typedef struct packed {
        logic active;
        logic done;
        logic is_new;
    } cpdi_flags_t;

endpackage
`default_nettype wire

// ----- design/cpdi_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cpdi_cell #(
    parameter int IDX_W = 8,
    parameter int CNT_W = 9
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [CNT_W-1:0]      count,
    input  wire cpdi_pkg::cpdi_flags_t in_flags,
    input  wire cpdi_pkg::cpdi_color_t in_color,
    input  wire logic [IDX_W-1:0]      in_idx,
    input  wire logic [IDX_W-1:0]      in_res_idx,
    output cpdi_pkg::cpdi_flags_t      out_flags,
    output cpdi_pkg::cpdi_color_t      out_color,
    output logic [IDX_W-1:0]           out_idx,
    output logic [IDX_W-1:0]           out_res_idx
);
    import cpdi_pkg::*;

    cpdi_color_t      entry_reg;
    cpdi_flags_t      flags_reg, flags_next;
    cpdi_color_t      color_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] res_reg, res_next;
    logic [CNT_W-1:0] idx_ext;
    logic             live;
    logic             match;
    logic             append;

    assign idx_ext = CNT_W'(in_idx);
    assign live    = in_flags.active && !in_flags.done;
    // This cell holds a valid entry when its index is below the count.
    assign match   = live && (idx_ext < count) && (entry_reg == in_color);
    // The first free slot takes the color when nothing matched before it.
    assign append  = live && (idx_ext == count);

    always_comb begin
        flags_next        = in_flags;
        flags_next.done   = in_flags.done | match | append;
        flags_next.is_new = in_flags.is_new | append;
        res_next          = (match || append) ? in_idx : in_res_idx;
        idx_next          = in_idx + IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        color_reg <= in_color;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
        if (append) begin
            entry_reg <= in_color;
        end
    end

    assign out_flags   = flags_reg;
    assign out_color   = color_reg;
    assign out_idx     = idx_reg;
    assign out_res_idx = res_reg;

endmodule
`default_nettype wire

// ----- design/color_palette_dedup_indexer_unit.sv -----
// Add item: the token walks every cell, then its result is registered (output stage or pending slot).
// Clear item: its result is registered straight from the accept, with no walk through the cells.
// One item at a time: an add item holds the input off until its token leaves the last cell;
// clears run at one per cycle while no result waits in the pending slot.
// A finished result may wait in the output stage while the next item is taken.
// Reset (aresetn low, synchronous) empties the palette and drops any item in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module color_palette_dedup_indexer_unit #(
    parameter int PALETTE_DEPTH = cpdi_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic [7:0]                        s_red,
    input  wire logic [7:0]                        s_green,
    input  wire logic [7:0]                        s_blue,
    input  wire logic [7:0]                        s_alpha,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [cpdi_pkg::INDEX_OUT_W-1:0]       m_palette_index,
    output logic                                   m_was_new,
    output logic                                   m_table_full
);
    import cpdi_pkg::*;

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    // Search token chain: slot 0 is fed here, slot k is the output of cell k-1.
    cpdi_flags_t      chain_flags [PALETTE_DEPTH+1];
    cpdi_color_t      chain_color [PALETTE_DEPTH+1];
    logic [IDX_W-1:0] chain_idx   [PALETTE_DEPTH+1];
    logic [IDX_W-1:0] chain_res   [PALETTE_DEPTH+1];

    cpdi_state_e      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Output stage plus one pending slot, so a result may wait while work goes on.
    logic             m_valid_reg;
    logic [INDEX_OUT_W-1:0] out_idx_reg;
    logic             out_new_reg;
    logic             out_full_reg;
    logic             pend_valid_reg;
    logic [INDEX_OUT_W-1:0] pend_idx_reg;
    logic             pend_new_reg;
    logic             pend_full_reg;

    logic             accept;
    logic             accept_add;
    logic             accept_clear;
    logic             scan_end;
    logic             done_evt;
    logic             out_free;
    logic [INDEX_OUT_W-1:0] res_idx;
    logic             res_new;
    logic             res_full;
    logic [IDX_W+INDEX_OUT_W-1:0] res_idx_wide;

    assign accept       = s_valid && s_ready;
    assign accept_add   = accept && (s_op == OP_ADD);
    assign accept_clear = accept && (s_op == OP_CLEAR);

    // Feed a fresh token into the first cell on an accepted add item.
    assign chain_flags[0] = '{active: accept_add, done: 1'b0, is_new: 1'b0};
    assign chain_color[0] = {s_red, s_green, s_blue, s_alpha};
    assign chain_idx[0]   = '0;
    assign chain_res[0]   = '0;

    for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
        cpdi_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .count       (count_reg),
            .in_flags    (chain_flags[k]),
            .in_color    (chain_color[k]),
            .in_idx      (chain_idx[k]),
            .in_res_idx  (chain_res[k]),
            .out_flags   (chain_flags[k+1]),
            .out_color   (chain_color[k+1]),
            .out_idx     (chain_idx[k+1]),
            .out_res_idx (chain_res[k+1])
        );
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept_add) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (chain_flags[PALETTE_DEPTH].active) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        s_ready  = 1'b0;
        scan_end = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready  = !pend_valid_reg;
            ST_SCAN: scan_end = chain_flags[PALETTE_DEPTH].active;
            default: s_ready  = 1'b0;
        endcase
    end

    assign done_evt = scan_end || accept_clear;
    assign out_free = !m_valid_reg || m_ready;

    // Keep the low bits of the index for the result field.
    assign res_idx_wide = {{INDEX_OUT_W{1'b0}}, chain_res[PALETTE_DEPTH]};

    // A token that leaves the chain unresolved found neither its color nor a free slot.
    always_comb begin
        res_idx  = '0;
        res_new  = 1'b0;
        res_full = 1'b0;
        if (scan_end) begin
            if (chain_flags[PALETTE_DEPTH].done) begin
                res_idx = res_idx_wide[INDEX_OUT_W-1:0];
                res_new = chain_flags[PALETTE_DEPTH].is_new;
            end else begin
                res_full = 1'b1;
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (accept_clear) begin
            count_next = '0;
        end else if (scan_end && chain_flags[PALETTE_DEPTH].is_new) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (pend_valid_reg) begin
                // Drain the pending result first; no item completes meanwhile.
                if (out_free) begin
                    m_valid_reg    <= 1'b1;
                    pend_valid_reg <= 1'b0;
                end
            end else if (done_evt) begin
                if (out_free) begin
                    m_valid_reg <= 1'b1;
                end else begin
                    pend_valid_reg <= 1'b1;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_valid_reg) begin
            if (out_free) begin
                out_idx_reg  <= pend_idx_reg;
                out_new_reg  <= pend_new_reg;
                out_full_reg <= pend_full_reg;
            end
        end else if (done_evt) begin
            if (out_free) begin
                out_idx_reg  <= res_idx;
                out_new_reg  <= res_new;
                out_full_reg <= res_full;
            end else begin
                pend_idx_reg  <= res_idx;
                pend_new_reg  <= res_new;
                pend_full_reg <= res_full;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_palette_index = out_idx_reg;
    assign m_was_new       = out_new_reg;
    assign m_table_full    = out_full_reg;

    `CPDI_ASSERT_AT(a_count_bound, count_reg <= CNT_W'(PALETTE_DEPTH), "entry count above depth")
    `CPDI_ASSERT_AT(a_pend_behind_out, !pend_valid_reg || m_valid_reg, "pending result without output")
    `CPDI_ASSERT_AT(a_no_new_and_full, !m_valid_reg || !(m_was_new && m_table_full), "new and full together")
    `CPDI_ASSERT_NEXT(a_clear_empties, accept_clear, count_reg == '0, "clear did not empty palette")
    `CPDI_ASSERT_NEXT(a_append_counts, scan_end && chain_flags[PALETTE_DEPTH].is_new, count_reg == $past(count_reg) + CNT_W'(1), "append did not bump count")

endmodule
`default_nettype wire

// ----- test/palette_index_checker.sv -----
`timescale 1ns / 1ps
module palette_index_checker #(
    parameter int DEPTH = cpdi_pkg::PALETTE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic [7:0] s_alpha,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_palette_index,
    input  logic       m_was_new,
    input  logic       m_table_full,
    output int         fail_count,
    output int         pending_count,
    output int         appended_count,
    output int         hit_count,
    output int         refused_count,
    output int         cleared_count
);
    import cpdi_pkg::*;

    typedef struct packed {
        logic [7:0] index;
        logic       was_new;
        logic       table_full;
    } palette_answer_t;

    cpdi_color_t     known_colors [DEPTH];
    int unsigned     known_count;
    palette_answer_t pending_answers [$];

    // Clear empties the table; else find the color among valid entries, or append it if room is left.
    function automatic palette_answer_t resolve_color_index(cpdi_op_e op, cpdi_color_t color);
        palette_answer_t answer;
        answer = '0;
        if (op == OP_CLEAR) begin
            known_count = 0;
            cleared_count++;
            return answer;
        end
        for (int i = 0; i < known_count; i++) begin
            if (known_colors[i] == color) begin
                answer.index = 8'(i);
                hit_count++;
                return answer;
            end
        end
        if (known_count >= DEPTH) begin
            answer.table_full = 1'b1;
            refused_count++;
            return answer;
        end
        known_colors[known_count] = color;
        answer.index   = 8'(known_count);
        answer.was_new = 1'b1;
        known_count++;
        appended_count++;
        return answer;
    endfunction

    always @(posedge aclk) begin
        palette_answer_t want;
        palette_answer_t fresh;
        if (!aresetn) begin
            known_count = 0;
            pending_answers.delete();
        end else begin
            // Retire the result first so a result never matches an item taken at the same edge.
            if (m_valid && m_ready) begin
                if (pending_answers.size() == 0) begin
                    $error("result with no item pending: palette_index %0d", m_palette_index);
                    fail_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_palette_index !== want.index) begin
                        $error("palette_index: expected %0d, got %0d",
                               want.index, m_palette_index);
                        fail_count++;
                    end
                    if (m_was_new !== want.was_new) begin
                        $error("was_new: expected %0d, got %0d", want.was_new, m_was_new);
                        fail_count++;
                    end
                    if (m_table_full !== want.table_full) begin
                        $error("table_full: expected %0d, got %0d",
                               want.table_full, m_table_full);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                fresh = resolve_color_index(cpdi_op_e'(s_op),
                                            {s_red, s_green, s_blue, s_alpha});
                pending_answers = {pending_answers, fresh};
            end
        end
        pending_count = pending_answers.size();
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import cpdi_pkg::*;

    localparam int PALETTE_DEPTH = PALETTE_DEPTH_DEF;
    localparam int TOTAL_ITEMS   = 1200;
    localparam int IDLE_PERCENT  = 32;
    // Receiver hold-off: long enough for the block to park one result and stall its input.
    localparam int STALL_CYCLES  = 900;
    localparam int STALL_AFTER   = 40;
    // Window (in items / results) where neither side idles.
    localparam int CALM_FIRST    = 600;
    localparam int CALM_LAST     = 800;
    // Each add item walks the whole palette; allow several times the slowest run.
    localparam int CYCLE_LIMIT   = 2_000_000;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    cpdi_op_e   s_op    = OP_ADD;
    logic [7:0] s_red   = '0;
    logic [7:0] s_green = '0;
    logic [7:0] s_blue  = '0;
    logic [7:0] s_alpha = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_palette_index;
    logic       m_was_new;
    logic       m_table_full;

    int fail_count;
    int pending_count;
    int appended_count;
    int hit_count;
    int refused_count;
    int cleared_count;

    int items_sent;
    int replies_taken;
    int cycle_count;
    int stall_left;
    bit stall_done;

    cpdi_color_t filled_colors [PALETTE_DEPTH];
    cpdi_color_t color_pool [16];

    color_palette_dedup_indexer_unit #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .s_alpha         (s_alpha),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_palette_index (m_palette_index),
        .m_was_new       (m_was_new),
        .m_table_full    (m_table_full)
    );

    palette_index_checker #(
        .DEPTH(PALETTE_DEPTH)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .s_alpha         (s_alpha),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_palette_index (m_palette_index),
        .m_was_new       (m_was_new),
        .m_table_full    (m_table_full),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .appended_count  (appended_count),
        .hit_count       (hit_count),
        .refused_count   (refused_count),
        .cleared_count   (cleared_count)
    );

    always #5 aclk = ~aclk;

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run aborted after %0d cycles with %0d results outstanding",
                     cycle_count, pending_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item; call at a rising edge, return at the edge that accepts it.
    // Drop valid for a random gap first, except inside the calm window.
    task automatic offer_item(input cpdi_op_e op, input cpdi_color_t color);
        bit calm;
        calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
        if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < IDLE_PERCENT)
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        {s_red, s_green, s_blue, s_alpha} <= color;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    // Result side: random back-pressure, one long hold-off, one calm window.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                replies_taken++;
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!stall_done && replies_taken >= STALL_AFTER) begin
                // Hold the output long enough that the input side backs up.
                stall_done = 1'b1;
                stall_left = STALL_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (replies_taken >= CALM_FIRST && replies_taken < CALM_LAST) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    initial begin
        cpdi_color_t base;
        cpdi_color_t color;
        int          pool_size;
        int          run_len;
        int          pick;
        int          lane;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: channel extremes, stored hits, single-channel differences.
        offer_item(OP_ADD, 32'h0000_0000);
        offer_item(OP_ADD, 32'hFFFF_FFFF);
        offer_item(OP_ADD, 32'h0000_0000);
        offer_item(OP_ADD, 32'hFFFF_FFFE);
        offer_item(OP_ADD, 32'hFEFF_FFFF);
        offer_item(OP_ADD, 32'hFFFE_FFFF);
        offer_item(OP_ADD, 32'hFFFF_FEFF);
        offer_item(OP_ADD, 32'hFFFF_FFFF);
        offer_item(OP_ADD, 32'hAA55_AA55);
        offer_item(OP_ADD, 32'h55AA_55AA);
        offer_item(OP_ADD, 32'hAA55_AA55);
        // Clear with nonzero color fields, then clear an empty table.
        offer_item(OP_CLEAR, 32'hFFFF_FFFF);
        offer_item(OP_CLEAR, 32'h0000_0000);
        // Stale entries must not match after a clear.
        offer_item(OP_ADD, 32'hFFFF_FFFF);
        offer_item(OP_ADD, 32'h0000_0000);
        offer_item(OP_ADD, 32'hFFFF_FFFF);
        offer_item(OP_CLEAR, 32'h1234_5678);

        // Fill the table to capacity; the red channel keeps every entry distinct.
        for (int i = 0; i < PALETTE_DEPTH; i++) begin
            color = {8'(i), 24'($urandom)};
            filled_colors[i] = color;
            offer_item(OP_ADD, color);
        end
        // New colors on a full table are refused; stored ones still resolve.
        for (int k = 0; k < 4; k++)
            offer_item(OP_ADD, filled_colors[k] ^ 32'h0000_0001);
        offer_item(OP_ADD, filled_colors[PALETTE_DEPTH-1]);
        offer_item(OP_ADD, filled_colors[0]);
        for (int k = 0; k < 6; k++)
            offer_item(OP_ADD, filled_colors[$urandom_range(PALETTE_DEPTH-1)]);
        offer_item(OP_ADD, $urandom);
        offer_item(OP_CLEAR, $urandom);

        // Random episodes: usually a clear, then mostly adds from a small pool of colors, many near one base.
        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(99) < 70)
                offer_item(OP_CLEAR, $urandom);
            pool_size = $urandom_range(16, 2);
            base = $urandom;
            for (int p = 0; p < pool_size; p++) begin
                case ($urandom_range(2))
                    0: color_pool[p] = $urandom;
                    1: begin
                        lane = $urandom_range(3);
                        color_pool[p] = base;
                        color_pool[p][8*lane +: 8] = 8'($urandom);
                    end
                    default: color_pool[p] = base ^ (32'h1 << $urandom_range(31));
                endcase
            end
            run_len = $urandom_range(40, 4);
            for (int r = 0; r < run_len; r++) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    offer_item(OP_CLEAR, $urandom);
                else if (pick < 20)
                    offer_item(OP_ADD, $urandom);
                else
                    offer_item(OP_ADD, color_pool[$urandom_range(pool_size-1)]);
            end
        end
        s_valid <= 1'b0;

        // Drain: wait for every result, then give a late extra result time to show up.
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (PALETTE_DEPTH + 16) @(posedge aclk);

        $display("Ran %0d items in %0d cycles: %0d appended, %0d found stored,",
                 items_sent, cycle_count, appended_count, hit_count);
        $display("%0d refused on a full table, %0d clears, %0d mismatches",
                 refused_count, cleared_count, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
